// ----- rtl/ssa_pkg.sv -----
// shared types and fixed widths for the sample statistics accumulator
package ssa_pkg;

  localparam int SAMPLE_W = 24;
  localparam int TOTAL_W  = 16;
  localparam int SUM_W    = 40;
  localparam int SUMSQ_W  = 64;
  localparam int WORD_W   = 32;
  localparam int ACC_W    = 96;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [TOTAL_W-1:0]  total_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [SUMSQ_W-1:0]  sumsq_t;
  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [ACC_W-1:0]    acc_t;

  // one incoming latency sample
  typedef struct packed {
    sample_t sample;
    logic    last;
  } in_item_t;

  // one batch result
  typedef struct packed {
    word_t   mean_q8;
    word_t   stddev_q8;
    sample_t minimum;
    sample_t maximum;
    total_t  sample_total;
    logic    overflowed;
  } out_item_t;

endpackage

// ----- rtl/ssa_stream_if.sv -----
// valid/ready request channel carrying one payload item
interface ssa_stream_if #(
  parameter type payload_t = ssa_pkg::in_item_t
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ----- rtl/sample_statistics_accumulator_top.sv -----
// sample statistics accumulator: count, sum, sum of squares, min, max, mean and std deviation
//
// Takes a batch of unsigned latency samples on the samples channel, one request per
// sample, with the final one flagged by last. Per sample the block keeps an exact count,
// sum, sum of squares, minimum and maximum; once the count reaches 2^COUNT_BITS-1 further
// samples are dropped and the overflowed flag is raised. On the final sample it emits one
// request on the results channel: mean_q8 = floor(sum*256/n) and
// stddev_q8 = floor(sqrt(floor((n*sumsq - sum^2)*65536/n^2))), both with 8 fraction bits,
// together with min, max, count and the overflow flag, then clears for the next batch.
// Sequence: an ordinary sample passes through capture, square on the shared 32x32 multiplier
// and accumulate, and no new sample is taken until it is through. After a final sample the
// block also forms the five partial products of the variance numerator and n*n through the same
// multiplier, runs the bit-serial variance division, the bit-serial square root and the
// mean division, and hands the result to the output register. The divider and root share
// one 65-bit subtractor and run one quotient or root bit per cycle. The result sits in an
// output register, so the next batch can begin while the result waits to be taken; the
// hand-over cycle only stalls if the previous result is still held there.
module sample_statistics_accumulator_top #(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  ssa_stream_if.sink   samples,
  ssa_stream_if.source results
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a sample
  localparam logic [2:0] S_SQ   = 3'd1;  // square the sample
  localparam logic [2:0] S_ACC  = 3'd2;  // fold sample into running sums
  localparam logic [2:0] S_MUL  = 3'd3;  // partial product of the numerator
  localparam logic [2:0] S_MACC = 3'd4;  // add partial product into numerator
  localparam logic [2:0] S_DIV  = 3'd5;  // one quotient bit per cycle
  localparam logic [2:0] S_SQRT = 3'd6;  // one root bit per cycle
  localparam logic [2:0] S_DONE = 3'd7;  // hand result to output register

  // numerator partial products: n*sumsq - sum*sum, sum split at bit 32, then n*n for the divisor
  localparam logic [2:0] STEP_NSQ_LO = 3'd0;
  localparam logic [2:0] STEP_NSQ_HI = 3'd1;
  localparam logic [2:0] STEP_SS_LL  = 3'd2;
  localparam logic [2:0] STEP_SS_LH  = 3'd3;
  localparam logic [2:0] STEP_SS_HH  = 3'd4;
  localparam logic [2:0] STEP_NN     = 3'd5;

  localparam logic [6:0] DIV_VAR_STEPS  = 7'd96;
  localparam logic [6:0] DIV_MEAN_STEPS = 7'd48;
  localparam logic [6:0] SQRT_STEPS     = 7'd32;

  logic [2:0] state;
  logic [2:0] step;
  logic [6:0] cnt;
  logic       div_mean;

  // captured sample
  logic [SAMPLE_BITS-1:0] samp;
  logic                   samp_last;

  // running statistics
  logic [COUNT_BITS-1:0] count;
  ssa_pkg::sum_t         sum;
  ssa_pkg::sumsq_t       sumsq;
  ssa_pkg::sample_t      run_min;
  ssa_pkg::sample_t      run_max;
  logic                  dropped;

  // batch-end datapath
  logic [63:0]       prod;
  ssa_pkg::acc_t     acc;      // numerator, then dividend shifter, then root radicand
  ssa_pkg::word_t    dvsr;
  ssa_pkg::word_t    rem;
  logic [63:0]       quot;
  logic [63:0]       sq_res;
  logic [63:0]       sq_bit;
  ssa_pkg::word_t    mean_r;
  ssa_pkg::word_t    sd_r;

  // output register
  logic               out_valid;
  ssa_pkg::out_item_t out_data;
  logic               out_free;

  ssa_pkg::word_t n_word;
  ssa_pkg::word_t samp_word;

  // shared multiplier
  ssa_pkg::word_t mul_a;
  ssa_pkg::word_t mul_b;
  logic [63:0]    mul_p;

  // shared subtractor for divide and root steps
  logic [64:0] sub_a;
  logic [64:0] sub_b;
  logic [65:0] sub_diff;
  logic        sub_ge;

  logic [63:0] quot_next;
  logic [63:0] sq_res_next;

  assign n_word    = ssa_pkg::word_t'(count);
  assign samp_word = ssa_pkg::word_t'(samp);

  assign samples.ready = (state == S_IDLE);
  assign results.valid = out_valid;
  assign results.data  = out_data;
  assign out_free      = !out_valid || results.ready;

  // multiplier operand select
  always_comb begin
    mul_a = samp_word;
    mul_b = samp_word;
    if (state == S_MUL) begin
      unique case (step)
        STEP_NSQ_LO: begin
          mul_a = n_word;
          mul_b = sumsq[31:0];
        end
        STEP_NSQ_HI: begin
          mul_a = n_word;
          mul_b = sumsq[63:32];
        end
        STEP_SS_LL: begin
          mul_a = sum[31:0];
          mul_b = sum[31:0];
        end
        STEP_SS_LH: begin
          mul_a = sum[31:0];
          mul_b = ssa_pkg::word_t'(sum[39:32]);
        end
        STEP_SS_HH: begin
          mul_a = ssa_pkg::word_t'(sum[39:32]);
          mul_b = ssa_pkg::word_t'(sum[39:32]);
        end
        STEP_NN: begin
          mul_a = n_word;
          mul_b = n_word;
        end
        default: begin
          mul_a = n_word;
          mul_b = n_word;
        end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  // subtractor operand select: partial remainder in division, radicand otherwise
  always_comb begin
    if (state == S_DIV) begin
      sub_a = 65'({rem, acc[95]});
      sub_b = 65'(dvsr);
    end else begin
      sub_a = {1'b0, acc[63:0]};
      sub_b = {1'b0, sq_res} + {1'b0, sq_bit};
    end
    sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    sub_ge   = ~sub_diff[65];
  end

  assign quot_next   = {quot[62:0], sub_ge};
  assign sq_res_next = sub_ge ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= STEP_NSQ_LO;
      cnt      <= '0;
      div_mean <= 1'b0;
      count    <= '0;
      sum      <= '0;
      sumsq    <= '0;
      run_min  <= '1;
      run_max  <= '0;
      dropped  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (samples.valid) begin
            samp      <= samples.data.sample[SAMPLE_BITS-1:0];
            samp_last <= samples.data.last;
            state     <= S_SQ;
          end
        end

        S_SQ: begin
          prod  <= mul_p;
          state <= S_ACC;
        end

        S_ACC: begin
          if (count == '1) begin
            dropped <= 1'b1;  // count limit reached, sample ignored
          end else begin
            count <= count + 1'b1;
            sum   <= sum + ssa_pkg::sum_t'(samp);
            sumsq <= sumsq + prod;
            if (ssa_pkg::sample_t'(samp) < run_min) begin
              run_min <= ssa_pkg::sample_t'(samp);
            end
            if (ssa_pkg::sample_t'(samp) > run_max) begin
              run_max <= ssa_pkg::sample_t'(samp);
            end
          end
          step  <= STEP_NSQ_LO;
          state <= samp_last ? S_MUL : S_IDLE;
        end

        S_MUL: begin
          prod  <= mul_p;
          state <= S_MACC;
        end

        S_MACC: begin
          case (step)
            STEP_NSQ_LO: acc <= ssa_pkg::acc_t'(prod);
            STEP_NSQ_HI: acc <= acc + (ssa_pkg::acc_t'(prod) << 32);
            STEP_SS_LL:  acc <= acc - ssa_pkg::acc_t'(prod);
            STEP_SS_LH:  acc <= acc - (ssa_pkg::acc_t'(prod) << 33);
            STEP_SS_HH:  acc <= acc - (ssa_pkg::acc_t'(prod) << 64);
            default: begin
              // n*n is in prod: start the variance division on numerator * 65536
              acc <= acc << 16;
            end
          endcase
          if (step == STEP_NN) begin
            dvsr     <= prod[31:0];
            rem      <= '0;
            quot     <= '0;
            cnt      <= DIV_VAR_STEPS;
            div_mean <= 1'b0;
            state    <= S_DIV;
          end else begin
            step  <= step + 1'b1;
            state <= S_MUL;
          end
        end

        S_DIV: begin
          rem  <= sub_ge ? sub_diff[31:0] : {rem[30:0], acc[95]};
          quot <= quot_next;
          if (cnt != 7'd1) begin
            acc <= acc << 1;
            cnt <= cnt - 1'b1;
          end else if (div_mean) begin
            mean_r <= quot_next[31:0];
            state  <= S_DONE;
          end else begin
            acc    <= ssa_pkg::acc_t'(quot_next);
            sq_res <= '0;
            sq_bit <= 64'd1 << 62;
            cnt    <= SQRT_STEPS;
            state  <= S_SQRT;
          end
        end

        S_SQRT: begin
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          if (cnt != 7'd1) begin
            if (sub_ge) begin
              acc <= {acc[95:64], sub_diff[63:0]};
            end
            cnt <= cnt - 1'b1;
          end else begin
            // root done: set up sum*256 / n
            sd_r     <= sq_res_next[31:0];
            acc      <= {sum, 56'd0};
            dvsr     <= n_word;
            rem      <= '0;
            quot     <= '0;
            cnt      <= DIV_MEAN_STEPS;
            div_mean <= 1'b1;
            state    <= S_DIV;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_data.mean_q8      <= mean_r;
            out_data.stddev_q8    <= sd_r;
            out_data.minimum      <= run_min;
            out_data.maximum      <= run_max;
            out_data.sample_total <= ssa_pkg::total_t'(count);
            out_data.overflowed   <= dropped;
            // clear for the next batch
            count   <= '0;
            sum     <= '0;
            sumsq   <= '0;
            run_min <= '1;
            run_max <= '0;
            dropped <= 1'b0;
            state   <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/ssa_checker.sv -----
// port-level checks for the sample statistics accumulator, bound to the top level
module ssa_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ssa_pkg::out_item_t out_data
);

  // a pending result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before taken");

  // an accepted sample drops ready while the block works on it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held across a sample accept");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // every result covers at least one sample and a consistent range
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.sample_total != 16'd0) &&
                  (out_data.minimum <= out_data.maximum))
    else $error("empty batch or min above max");

  // mean lies between min and max
  a_mean_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.mean_q8 >= {out_data.minimum, 8'd0}) &&
                  (out_data.mean_q8 <= {out_data.maximum, 8'd0}))
    else $error("mean outside sample range");

endmodule

bind sample_statistics_accumulator_top ssa_checker u_ssa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_data  (results.data)
);

// ----- test/tb.sv -----
// self-checking testbench for the sample statistics accumulator
`timescale 1ns / 1ps

module tb;

  // block configuration, kept in step with the instance below
  localparam int SAMPLE_BITS  = 24;
  localparam int COUNT_BITS   = 16;
  localparam int COUNT_LIMIT  = (1 << COUNT_BITS) - 1;
  localparam ssa_pkg::sample_t SAMPLE_MASK = ssa_pkg::sample_t'((64'd1 << SAMPLE_BITS) - 1);

  // size of the random part, in samples
  localparam int RANDOM_SAMPLES = 1750;
  // settle for longer than a final sample keeps the block busy
  localparam int SETTLE_CYCLES = 250;

  // how the samples of one random batch are spread
  typedef enum int unsigned {
    SPREAD_FULL,
    SPREAD_LOW,
    SPREAD_CLUSTER,
    SPREAD_EXTREME,
    SPREAD_ONEHOT
  } spread_t;

  // -------------------------------------------------------------------------
  // running batch statistics and the queue of batch results still owed
  // -------------------------------------------------------------------------
  class batch_stats_t;
    int unsigned        kept;
    ssa_pkg::sum_t      sum_acc;
    ssa_pkg::sumsq_t    sq_acc;
    ssa_pkg::sample_t   lowest;
    ssa_pkg::sample_t   highest;
    logic               dropped;
    ssa_pkg::out_item_t owed_results[$];
    int unsigned        mismatches;
    int unsigned        checked;

    function new();
      restart();
      mismatches = 0;
      checked    = 0;
    endfunction

    function void restart();
      kept    = 0;
      sum_acc = '0;
      sq_acc  = '0;
      lowest  = '1;
      highest = '0;
      dropped = 1'b0;
    endfunction

    // floored square root, one root bit per pass from the top down
    function ssa_pkg::word_t floor_root(logic [63:0] x);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= x) root = trial;
      end
      return ssa_pkg::word_t'(root);
    endfunction

    // fold one accepted sample in; on the final one work out the batch result
    function void take_sample(ssa_pkg::in_item_t req);
      ssa_pkg::sample_t   s;
      logic [127:0]       n_w, s_w, q_w, num, scaled, quot;
      logic [63:0]        var_q8;
      ssa_pkg::out_item_t res;
      s = req.sample & SAMPLE_MASK;
      if (kept >= COUNT_LIMIT) begin
        dropped = 1'b1;
      end else begin
        kept++;
        sum_acc = sum_acc + ssa_pkg::sum_t'(s);
        sq_acc  = sq_acc + ssa_pkg::sumsq_t'(s) * ssa_pkg::sumsq_t'(s);
        if (s < lowest) lowest = s;
        if (s > highest) highest = s;
      end
      if (!req.last) return;
      res = '0;
      if (kept != 0) begin
        n_w    = 128'(kept);
        s_w    = 128'(sum_acc);
        q_w    = 128'(sq_acc);
        num    = n_w * q_w - s_w * s_w;
        scaled = num << 16;
        quot   = scaled / (n_w * n_w);
        var_q8 = (quot[127:64] != 0) ? '1 : quot[63:0];
        res.mean_q8   = ssa_pkg::word_t'((s_w << 8) / n_w);
        res.stddev_q8 = floor_root(var_q8);
      end
      res.minimum      = lowest;
      res.maximum      = highest;
      res.sample_total = ssa_pkg::total_t'(kept);
      res.overflowed   = dropped;
      owed_results     = {owed_results, res};
      restart();
    endfunction

    task log_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("mismatch on %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
    endtask

    task compare_result(ssa_pkg::out_item_t got);
      ssa_pkg::out_item_t want;
      checked++;
      if (owed_results.size() == 0) begin
        log_mismatch("unexpected result", 64'(got.sample_total), 64'd0);
        return;
      end
      want = owed_results.pop_front();
      if (got.mean_q8 !== want.mean_q8)
        log_mismatch("mean_q8", 64'(got.mean_q8), 64'(want.mean_q8));
      if (got.stddev_q8 !== want.stddev_q8)
        log_mismatch("stddev_q8", 64'(got.stddev_q8), 64'(want.stddev_q8));
      if (got.minimum !== want.minimum)
        log_mismatch("minimum", 64'(got.minimum), 64'(want.minimum));
      if (got.maximum !== want.maximum)
        log_mismatch("maximum", 64'(got.maximum), 64'(want.maximum));
      if (got.sample_total !== want.sample_total)
        log_mismatch("sample_total", 64'(got.sample_total), 64'(want.sample_total));
      if (got.overflowed !== want.overflowed)
        log_mismatch("overflowed", 64'(got.overflowed), 64'(want.overflowed));
    endtask
  endclass

  // -------------------------------------------------------------------------
  // clock, channels and the block itself
  // -------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ssa_stream_if #(.payload_t(ssa_pkg::in_item_t))  sample_ch ();
  ssa_stream_if #(.payload_t(ssa_pkg::out_item_t)) result_ch ();

  sample_statistics_accumulator_top #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (result_ch)
  );

  batch_stats_t stats = new();

  // samples of the batch about to be sent, the last one carries the marker
  ssa_pkg::sample_t batch_vals[$];
  int unsigned      samples_sent;
  int unsigned      batches_sent;

  function automatic int unsigned pick_gap();
    return $urandom_range(0, 8);
  endfunction

  function automatic ssa_pkg::sample_t pick_sample(spread_t spread, ssa_pkg::sample_t centre);
    case (spread)
      SPREAD_FULL:    return ssa_pkg::sample_t'($urandom);
      SPREAD_LOW:     return ssa_pkg::sample_t'($urandom_range(0, 255));
      SPREAD_CLUSTER: return centre ^ ssa_pkg::sample_t'($urandom_range(0, 15));
      SPREAD_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
      default:        return ssa_pkg::sample_t'(1) << $urandom_range(0, SAMPLE_BITS - 1);
    endcase
  endfunction

  // one sample request, held until the block takes it
  task automatic send_sample(ssa_pkg::sample_t s, logic is_last, int unsigned gap);
    ssa_pkg::in_item_t req;
    req.sample = s;
    req.last   = is_last;
    if (gap != 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.data  <= req;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    stats.take_sample(req);
    samples_sent++;
  endtask

  task automatic send_batch();
    foreach (batch_vals[i])
      send_sample(batch_vals[i], i == batch_vals.size() - 1, pick_gap());
    batches_sent++;
  endtask

  // result side: random back-pressure, every accepted result checked at once
  task automatic take_results();
    int unsigned stall;
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      stats.compare_result(result_ch.data);
    end
  endtask

  // sender holds off until every owed result has come back
  task automatic wait_for_results();
    sample_ch.valid <= 1'b0;
    while (stats.owed_results.size() != 0) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // stimulus
  // -------------------------------------------------------------------------
  initial begin
    int unsigned      random_sent;
    int unsigned      len;
    spread_t          spread;
    ssa_pkg::sample_t centre;

    rst             <= 1'b1;
    sample_ch.valid <= 1'b0;
    sample_ch.data  <= '0;
    result_ch.ready <= 1'b0;
    samples_sent = 0;
    batches_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    fork
      take_results();
    join_none

    // directed: single-sample batches at both ends of the range
    batch_vals = '{24'h000000};
    send_batch();
    batch_vals = '{24'hFFFFFF};
    send_batch();
    // widest spread the fields allow, in both orders
    batch_vals = '{24'h000000, 24'hFFFFFF};
    send_batch();
    batch_vals = '{24'hFFFFFF, 24'h000000, 24'hFFFFFF};
    send_batch();
    // identical samples give a zero deviation
    batch_vals = '{24'd5, 24'd5, 24'd5, 24'd5};
    send_batch();
    // small values where the fraction bits matter, then mixed bit patterns
    batch_vals = '{24'd1, 24'd2};
    send_batch();
    batch_vals = '{24'h800000, 24'h7FFFFF, 24'h000001, 24'hAAAAAA, 24'h555555};
    send_batch();
    batch_vals = '{24'd0, 24'd0, 24'd1};
    send_batch();

    // pause the sender until the pipeline is empty
    wait_for_results();

    // random batches: mostly short, some long, mixed spreads and idling
    random_sent = 0;
    while (random_sent < RANDOM_SAMPLES) begin
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
      spread = spread_t'($urandom_range(0, 4));
      centre = ssa_pkg::sample_t'($urandom);
      batch_vals.delete();
      repeat (len) batch_vals = {batch_vals, pick_sample(spread, centre)};
      send_batch();
      random_sent += len;
    end
    sample_ch.valid <= 1'b0;

    // drain, then give the block time to show any stray result
    while (stats.owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d samples in %0d batches, %0d results checked",
             samples_sent, batches_sent, stats.checked);
    $display("range extremes, flat and clustered batches, random idling, one full drain");
    if (stats.mismatches == 0 && stats.owed_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run
  initial begin
    #60_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
